FILE: sv/sfld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfld_pkg
// Shared types, constants and the control store of the status frame display.
// ----------------------------------------------------------------------------
package sfld_pkg;

  localparam int FRAME_BYTES = 4;
  localparam int FB_BYTES    = 512;
  localparam int FB_WORDS    = FB_BYTES / 2;
  localparam int FB_IDX_W    = $clog2(FB_WORDS);
  localparam int FONT_BYTES  = 160;
  localparam int FONT_IDX_W  = $clog2(FONT_BYTES);
  localparam int ROWS        = 16;
  localparam int PC_W        = 5;

  localparam logic [7:0] START_BYTE = 8'h80;
  localparam logic [7:0] END_BYTE   = 8'hFF;

  localparam logic [1:0] CMD_SERIAL    = 2'd0;
  localparam logic [1:0] CMD_TICK      = 2'd1;
  localparam logic [1:0] CMD_LOAD_FB   = 2'd2;
  localparam logic [1:0] CMD_LOAD_FONT = 2'd3;

  typedef logic [PC_W-1:0] pc_t;

  // Program layout: dispatch lands at PC_SERIAL + cmd.
  localparam pc_t PC_CLEAR     = 5'd0;
  localparam pc_t PC_FETCH     = 5'd1;
  localparam pc_t PC_SERIAL    = 5'd2;
  localparam pc_t PC_SCAN_RD   = 5'd3;
  localparam pc_t PC_LOAD_FB   = 5'd4;
  localparam pc_t PC_LOAD_FONT = 5'd5;
  localparam pc_t PC_SCAN_OUT  = 5'd6;
  localparam pc_t PC_DRAW      = 5'd7;

  typedef enum logic [3:0] {
    OP_CLEAR,
    OP_FETCH,
    OP_SERIAL,
    OP_SCAN_RD,
    OP_LOAD_FB,
    OP_LOAD_FONT,
    OP_SCAN_OUT,
    OP_GSET,
    OP_GROW
  } op_t;

  typedef enum logic [1:0] {
    DIG_HUND,
    DIG_TENS,
    DIG_ONES
  } dig_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] cell_id;
    logic       side;
    logic [1:0] vsel;
    dig_t       dsel;
    pc_t        tgt;
  } ucode_t;

  typedef struct packed {
    logic                we_left;
    logic                we_right;
    logic [FB_IDX_W-1:0] index;
    logic [7:0]          data;
  } fb_wr_t;

  function automatic ucode_t uw(input op_t op, input logic [3:0] cell_id, input logic side,
                                input logic [1:0] vsel, input dig_t dsel, input pc_t tgt);
    ucode_t w;
    w.op      = op;
    w.cell_id = cell_id;
    w.side    = side;
    w.vsel    = vsel;
    w.dsel    = dsel;
    w.tgt     = tgt;
    return w;
  endfunction

  // Control store: one word per step.
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      5'd0:    w = uw(OP_CLEAR,     4'd0,  1'b0, 2'd0, DIG_ONES, PC_FETCH);
      5'd1:    w = uw(OP_FETCH,     4'd0,  1'b0, 2'd0, DIG_ONES, PC_SERIAL);
      5'd2:    w = uw(OP_SERIAL,    4'd0,  1'b0, 2'd0, DIG_ONES, PC_DRAW);
      5'd3:    w = uw(OP_SCAN_RD,   4'd0,  1'b0, 2'd0, DIG_ONES, PC_SCAN_OUT);
      5'd4:    w = uw(OP_LOAD_FB,   4'd0,  1'b0, 2'd0, DIG_ONES, PC_FETCH);
      5'd5:    w = uw(OP_LOAD_FONT, 4'd0,  1'b0, 2'd0, DIG_ONES, PC_FETCH);
      5'd6:    w = uw(OP_SCAN_OUT,  4'd0,  1'b0, 2'd0, DIG_ONES, PC_FETCH);
      5'd7:    w = uw(OP_GSET,      4'd2,  1'b0, 2'd0, DIG_TENS, 5'd8);
      5'd8:    w = uw(OP_GROW,      4'd2,  1'b0, 2'd0, DIG_TENS, 5'd9);
      5'd9:    w = uw(OP_GSET,      4'd2,  1'b1, 2'd0, DIG_ONES, 5'd10);
      5'd10:   w = uw(OP_GROW,      4'd2,  1'b1, 2'd0, DIG_ONES, 5'd11);
      5'd11:   w = uw(OP_GSET,      4'd6,  1'b1, 2'd1, DIG_HUND, 5'd12);
      5'd12:   w = uw(OP_GROW,      4'd6,  1'b1, 2'd1, DIG_HUND, 5'd13);
      5'd13:   w = uw(OP_GSET,      4'd7,  1'b0, 2'd1, DIG_TENS, 5'd14);
      5'd14:   w = uw(OP_GROW,      4'd7,  1'b0, 2'd1, DIG_TENS, 5'd15);
      5'd15:   w = uw(OP_GSET,      4'd7,  1'b1, 2'd1, DIG_ONES, 5'd16);
      5'd16:   w = uw(OP_GROW,      4'd7,  1'b1, 2'd1, DIG_ONES, 5'd17);
      5'd17:   w = uw(OP_GSET,      4'd10, 1'b1, 2'd2, DIG_HUND, 5'd18);
      5'd18:   w = uw(OP_GROW,      4'd10, 1'b1, 2'd2, DIG_HUND, 5'd19);
      5'd19:   w = uw(OP_GSET,      4'd11, 1'b0, 2'd2, DIG_TENS, 5'd20);
      5'd20:   w = uw(OP_GROW,      4'd11, 1'b0, 2'd2, DIG_TENS, 5'd21);
      5'd21:   w = uw(OP_GSET,      4'd11, 1'b1, 2'd2, DIG_ONES, 5'd22);
      5'd22:   w = uw(OP_GROW,      4'd11, 1'b1, 2'd2, DIG_ONES, 5'd23);
      5'd23:   w = uw(OP_GSET,      4'd14, 1'b1, 2'd3, DIG_HUND, 5'd24);
      5'd24:   w = uw(OP_GROW,      4'd14, 1'b1, 2'd3, DIG_HUND, 5'd25);
      5'd25:   w = uw(OP_GSET,      4'd15, 1'b0, 2'd3, DIG_TENS, 5'd26);
      5'd26:   w = uw(OP_GROW,      4'd15, 1'b0, 2'd3, DIG_TENS, 5'd27);
      5'd27:   w = uw(OP_GSET,      4'd15, 1'b1, 2'd3, DIG_ONES, 5'd28);
      5'd28:   w = uw(OP_GROW,      4'd15, 1'b1, 2'd3, DIG_ONES, PC_FETCH);
      default: w = uw(OP_FETCH,     4'd0,  1'b0, 2'd0, DIG_ONES, PC_SERIAL);
    endcase
    return w;
  endfunction

endpackage

FILE: sv/status_frame_led_matrix_display.sv
`timescale 1ns / 1ps
// Sequence: a tick fetches, then gives the 16 cells of one row, each as a framebuffer
// read followed by an output load that waits while the output stalls. A frame closed
// by 0xFF then draws 11 glyphs, one glyph row at a time through the single font read
// port; no item is taken meanwhile.
// Reset: synchronous; the framebuffer is cleared after reset, one word a cycle, before
// the first item is taken.
// ----------------------------------------------------------------------------
// status_frame_led_matrix_display
// Serial status frame parser and LED matrix scanner, run by a microcoded
// sequencer over a framebuffer and a digit font.
// ----------------------------------------------------------------------------
module status_frame_led_matrix_display (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] data_byte,
  input  logic [8:0] load_address,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] row_select,
  output logic [3:0] cell_index,
  output logic [7:0] left_bits,
  output logic [7:0] right_bits,
  output logic       last
);
  import sfld_pkg::*;

  pc_t                 pc;
  pc_t                 pc_next;
  ucode_t              cw;
  logic [FB_IDX_W-1:0] cnt;
  logic [FB_IDX_W-1:0] cnt_next;

  logic [1:0] item_cmd;
  logic [7:0] item_data;
  logic [8:0] item_addr;

  logic       frame_open;
  logic [2:0] byte_index;
  logic [7:0] frame_values [FRAME_BYTES];
  logic [3:0] digit;
  logic [3:0] scan_row;

  logic [7:0] font_mem [FONT_BYTES];
  logic [7:0] font_rd;

  fb_wr_t              fb_wr;
  logic                fb_rd_en;
  logic [FB_IDX_W-1:0] fb_rd_index;
  logic [7:0]          fb_rd_left;
  logic [7:0]          fb_rd_right;

  logic       in_fire;
  logic       out_load;
  logic       frame_done;
  logic [7:0] dval;
  logic [1:0] d_hund;
  logic [6:0] d_rem;
  logic [14:0] d_prod;
  logic [3:0] d_tens;
  logic [6:0] d_ones;
  logic [3:0] digit_sel;

  assign cw         = ucode_rom(pc);
  assign in_stall   = (cw.op != OP_FETCH);
  assign in_fire    = in_valid && !in_stall;
  assign out_load   = (cw.op == OP_SCAN_OUT) && (!out_valid || !out_stall);
  assign frame_done = (item_data != START_BYTE) && frame_open &&
                      (byte_index == 3'(FRAME_BYTES)) && (item_data == END_BYTE);

  // Decimal digits of the selected frame value; x/10 by reciprocal for x < 100.
  always_comb begin
    dval = frame_values[cw.vsel];
    if (dval >= 8'd200) begin
      d_hund = 2'd2;
      d_rem  = 7'(dval - 8'd200);
    end else if (dval >= 8'd100) begin
      d_hund = 2'd1;
      d_rem  = 7'(dval - 8'd100);
    end else begin
      d_hund = 2'd0;
      d_rem  = dval[6:0];
    end
    d_prod = 15'(d_rem) * 15'd205;
    d_tens = d_prod[14:11];
    d_ones = d_rem - 7'(d_tens) * 7'd10;
    unique case (cw.dsel)
      DIG_HUND: digit_sel = {2'b00, d_hund};
      DIG_TENS: digit_sel = d_tens;
      default:  digit_sel = d_ones[3:0];
    endcase
  end

  // Sequencer: next step and loop count.
  always_comb begin
    pc_next  = pc;
    cnt_next = cnt;
    unique case (cw.op)
      OP_CLEAR: begin
        cnt_next = cnt + 1'b1;
        if (cnt == FB_IDX_W'(FB_WORDS - 1)) begin
          pc_next = cw.tgt;
        end
      end
      OP_FETCH: begin
        if (in_valid) begin
          pc_next = cw.tgt + PC_W'(cmd);
        end
      end
      OP_SERIAL: begin
        pc_next = frame_done ? cw.tgt : PC_FETCH;
      end
      OP_SCAN_RD, OP_LOAD_FB, OP_LOAD_FONT, OP_GSET: begin
        pc_next = cw.tgt;
      end
      OP_SCAN_OUT: begin
        if (out_load) begin
          if (cnt[3:0] == 4'd15) begin
            cnt_next = '0;
            pc_next  = cw.tgt;
          end else begin
            cnt_next = cnt + 1'b1;
            pc_next  = PC_SCAN_RD;
          end
        end
      end
      OP_GROW: begin
        if (cnt[4]) begin
          cnt_next = '0;
          pc_next  = cw.tgt;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        pc_next = PC_FETCH;
      end
    endcase
  end

  // Framebuffer port control.
  always_comb begin
    fb_wr.we_left  = 1'b0;
    fb_wr.we_right = 1'b0;
    fb_wr.index    = cnt;
    fb_wr.data     = 8'h00;
    unique case (cw.op)
      OP_CLEAR: begin
        fb_wr.we_left  = 1'b1;
        fb_wr.we_right = 1'b1;
      end
      OP_LOAD_FB: begin
        fb_wr.we_left  = !item_addr[0];
        fb_wr.we_right = item_addr[0];
        fb_wr.index    = item_addr[8:1];
        fb_wr.data     = item_data;
      end
      OP_GROW: begin
        // write the row fetched last cycle
        fb_wr.we_left  = (cnt != '0) && !cw.side;
        fb_wr.we_right = (cnt != '0) && cw.side;
        fb_wr.index    = {cw.cell_id, cnt[3:0] - 4'd1};
        fb_wr.data     = font_rd;
      end
      default: begin
      end
    endcase
  end

  assign fb_rd_en    = (cw.op == OP_SCAN_RD);
  assign fb_rd_index = {cnt[3:0], scan_row};

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= PC_CLEAR;
      cnt        <= '0;
      frame_open <= 1'b0;
      byte_index <= '0;
      scan_row   <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        frame_values[i] <= '0;
      end
    end else begin
      pc  <= pc_next;
      cnt <= cnt_next;
      if (cw.op == OP_SERIAL) begin
        if (item_data == START_BYTE) begin
          frame_open <= 1'b1;
          byte_index <= '0;
        end else if (frame_open) begin
          if (byte_index == 3'(FRAME_BYTES)) begin
            frame_open <= 1'b0;
          end else begin
            frame_values[byte_index[1:0]] <= item_data;
            byte_index <= byte_index + 3'd1;
          end
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
        if (cnt[3:0] == 4'd15) begin
          scan_row <= scan_row + 4'd1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item latch, result register, digit and font store.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_cmd  <= cmd;
      item_data <= data_byte;
      item_addr <= load_address;
    end
    if (out_load) begin
      row_select <= scan_row;
      cell_index <= cnt[3:0];
      left_bits  <= ~fb_rd_left;
      right_bits <= ~fb_rd_right;
      last       <= (cnt[3:0] == 4'd15);
    end
    if (cw.op == OP_GSET) begin
      digit <= digit_sel;
    end
    if (cw.op == OP_LOAD_FONT && item_addr < 9'(FONT_BYTES)) begin
      font_mem[item_addr[FONT_IDX_W-1:0]] <= item_data;
    end
    if (cw.op == OP_GROW && !cnt[4]) begin
      font_rd <= font_mem[{digit, cnt[3:0]}];
    end
  end

  sfld_fb_mem u_fb (
    .clk      (clk),
    .wr       (fb_wr),
    .rd_en    (fb_rd_en),
    .rd_index (fb_rd_index),
    .rd_left  (fb_rd_left),
    .rd_right (fb_rd_right)
  );

  // The item latch holds the command that the dispatch already decoded.
  a_dispatch_cmd: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (item_cmd == $past(cmd)) && (pc == PC_SERIAL + PC_W'($past(cmd))))
    else $error("dispatch does not follow the latched command");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (scan_row == row_select + 4'd1))
    else $error("scan row not advanced with the last cell");

  a_last_load: assert property (@(posedge clk) disable iff (rst)
    (out_load && cnt[3:0] == 4'd15) |=> (out_valid && last && pc == PC_FETCH))
    else $error("last cell not presented on return to fetch");

  a_grow_count: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_GROW) |-> (cnt <= FB_IDX_W'(ROWS)))
    else $error("glyph row count out of range");

endmodule

FILE: sv/sfld_fb_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfld_fb_mem
// Framebuffer in two byte banks (left, right) sharing one word index, so both
// halves of a cell row are read together. Read data is registered.
// ----------------------------------------------------------------------------
module sfld_fb_mem (
  input  logic                            clk,
  input  sfld_pkg::fb_wr_t                wr,
  input  logic                            rd_en,
  input  logic [sfld_pkg::FB_IDX_W-1:0]   rd_index,
  output logic [7:0]                      rd_left,
  output logic [7:0]                      rd_right
);
  import sfld_pkg::*;

  logic [7:0] bank_left  [FB_WORDS];
  logic [7:0] bank_right [FB_WORDS];

  always_ff @(posedge clk) begin
    if (wr.we_left) begin
      bank_left[wr.index] <= wr.data;
    end
    if (wr.we_right) begin
      bank_right[wr.index] <= wr.data;
    end
    if (rd_en) begin
      rd_left  <= bank_left[rd_index];
      rd_right <= bank_right[rd_index];
    end
  end

endmodule
